@@ sv/crlf_pkg.sv @@
// shared types, constants and codes of the clipped rectangle and line fill engine
package crlf_pkg;

	localparam int unsigned FB_WIDTH = 320;
	localparam int unsigned FB_HEIGHT = 240;
	localparam int unsigned FB_DEPTH = FB_WIDTH * FB_HEIGHT;
	localparam int unsigned ADDR_W = $clog2(FB_DEPTH);

	localparam int unsigned COORD_W = 10;
	localparam int unsigned COLOR_W = 24;
	localparam int unsigned COUNT_W = 17;
	localparam int unsigned MODE_W = 2;

	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 10;

	localparam int unsigned CMDQ_DEPTH = 2;
	localparam int unsigned CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
	localparam int unsigned CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] REG_OVERLAY_ON = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OV_LEFT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OV_TOP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OV_RIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OV_BOTTOM = 3'd4;

	typedef enum logic [MODE_W-1:0] {
		MODE_RECT,
		MODE_HLINE,
		MODE_VLINE,
		MODE_READ
	} mode_t;

	typedef enum logic [1:0] {
		CK_EMPTY,
		CK_REJECT,
		CK_READ,
		CK_DRAW
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic [COORD_W-1:0] x_lo;
		logic [COORD_W-1:0] x_hi;
		logic [COORD_W-1:0] y_lo;
		logic [COORD_W-1:0] y_hi;
		logic [COLOR_W-1:0] color;
		logic is_top;
	} cmd_t;

	typedef struct packed {
		logic on;
		logic [COORD_W-1:0] left;
		logic [COORD_W-1:0] top;
		logic [COORD_W-1:0] right;
		logic [COORD_W-1:0] bottom;
	} overlay_cfg_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DRAW,
		BK_READ,
		BK_DONE
	} back_state_t;

endpackage

@@ sv/crlf_ram.sv @@
// generic single write port, single read port ram with registered read
module crlf_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ sv/crlf_front.sv @@
// front end: checks a request against its context and clips it to the context and the frame
module crlf_front (
	input  logic [crlf_pkg::MODE_W-1:0]  mode,
	input  logic [crlf_pkg::COORD_W-1:0] pos_x,
	input  logic [crlf_pkg::COORD_W-1:0] pos_y,
	input  logic [crlf_pkg::COORD_W-1:0] span_x,
	input  logic [crlf_pkg::COORD_W-1:0] span_y,
	input  logic [crlf_pkg::COLOR_W-1:0] color,
	input  logic [crlf_pkg::COORD_W-1:0] ctx_left,
	input  logic [crlf_pkg::COORD_W-1:0] ctx_top,
	input  logic [crlf_pkg::COORD_W-1:0] ctx_right,
	input  logic [crlf_pkg::COORD_W-1:0] ctx_bottom,
	input  logic                         ctx_is_top,
	output crlf_pkg::cmd_t               cmd
);
	import crlf_pkg::*;

	localparam logic [COORD_W:0] FB_W_LIM = (COORD_W+1)'(FB_WIDTH);
	localparam logic [COORD_W:0] FB_H_LIM = (COORD_W+1)'(FB_HEIGHT);
	localparam logic [COORD_W-1:0] X_MAX = COORD_W'(FB_WIDTH - 1);
	localparam logic [COORD_W-1:0] Y_MAX = COORD_W'(FB_HEIGHT - 1);

	logic [COORD_W:0]   x0, y0;
	logic               start_bad;
	logic [COORD_W+1:0] rect_x_end, rect_y_end;
	logic [COORD_W-1:0] rect_x1, rect_y1;
	logic [COORD_W:0]   hl_x_end, vl_y_end;
	logic [COORD_W-1:0] hl_x1, vl_y1;
	logic [COORD_W-1:0] x1, y1;
	logic               reject, draw;
	logic               start_in_frame;

	always_comb begin
		x0 = {1'b0, pos_x} + {1'b0, ctx_left};
		y0 = {1'b0, pos_y} + {1'b0, ctx_top};
		start_bad = (x0 > {1'b0, ctx_right}) || (y0 > {1'b0, ctx_bottom});

		// rectangle end is start plus span minus one, clamped to the context
		rect_x_end = {1'b0, x0} + {2'b00, span_x} - (COORD_W+2)'(1);
		rect_y_end = {1'b0, y0} + {2'b00, span_y} - (COORD_W+2)'(1);
		rect_x1 = (rect_x_end > {2'b00, ctx_right}) ? ctx_right : rect_x_end[COORD_W-1:0];
		rect_y1 = (rect_y_end > {2'b00, ctx_bottom}) ? ctx_bottom : rect_y_end[COORD_W-1:0];

		hl_x_end = {1'b0, span_x} + {1'b0, ctx_left};
		vl_y_end = {1'b0, span_y} + {1'b0, ctx_top};
		hl_x1 = (hl_x_end > {1'b0, ctx_right}) ? ctx_right : hl_x_end[COORD_W-1:0];
		vl_y1 = (vl_y_end > {1'b0, ctx_bottom}) ? ctx_bottom : vl_y_end[COORD_W-1:0];

		reject = 1'b0;
		draw = 1'b0;
		x1 = x0[COORD_W-1:0];
		y1 = y0[COORD_W-1:0];
		unique case (mode_t'(mode))
			MODE_RECT: begin
				reject = start_bad;
				draw = !start_bad && (span_x != '0) && (span_y != '0);
				x1 = rect_x1;
				y1 = rect_y1;
			end
			MODE_HLINE: begin
				reject = (span_x < pos_x) || start_bad;
				draw = !reject;
				x1 = hl_x1;
			end
			MODE_VLINE: begin
				reject = (span_y < pos_y) || start_bad;
				draw = !reject;
				y1 = vl_y1;
			end
			MODE_READ: begin
				reject = 1'b0;
				draw = 1'b0;
			end
			default: begin
				reject = 1'b0;
				draw = 1'b0;
			end
		endcase

		cmd.color = color;
		cmd.is_top = ctx_is_top;
		cmd.kind = CK_EMPTY;
		cmd.x_lo = x0[COORD_W-1:0];
		cmd.y_lo = y0[COORD_W-1:0];
		cmd.x_hi = ({1'b0, x1} >= FB_W_LIM) ? X_MAX : x1;
		cmd.y_hi = ({1'b0, y1} >= FB_H_LIM) ? Y_MAX : y1;
		start_in_frame = (x0 < FB_W_LIM) && (y0 < FB_H_LIM);

		if (mode_t'(mode) == MODE_READ) begin
			// read uses absolute coordinates, outside the frame reads as zero
			cmd.x_lo = pos_x;
			cmd.y_lo = pos_y;
			if (({1'b0, pos_x} < FB_W_LIM) && ({1'b0, pos_y} < FB_H_LIM)) begin
				cmd.kind = CK_READ;
			end
		end else if (reject) begin
			cmd.kind = CK_REJECT;
		end else if (draw && start_in_frame) begin
			cmd.kind = CK_DRAW;
		end
	end

endmodule

@@ sv/crlf_cmd_queue.sv @@
// short request queue between the front end and the pixel sequencer
module crlf_cmd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  crlf_pkg::cmd_t wr_cmd,
	output logic           full,
	input  logic           rd_en,
	output logic           rd_valid,
	output crlf_pkg::cmd_t rd_cmd
);
	import crlf_pkg::*;

	localparam logic [CMDQ_PTR_W-1:0] PTR_LAST = CMDQ_PTR_W'(CMDQ_DEPTH - 1);
	localparam logic [CMDQ_CNT_W-1:0] CNT_FULL = CMDQ_CNT_W'(CMDQ_DEPTH);

	cmd_t                  entry_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CMDQ_CNT_W-1:0] count_q;
	logic                  do_wr, do_rd;

	assign full = (count_q == CNT_FULL);
	assign rd_valid = (count_q != '0);
	assign rd_cmd = entry_q[rd_ptr_q];
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + CMDQ_PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + CMDQ_PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CMDQ_CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CMDQ_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_cmd;
		end
	end

endmodule

@@ sv/crlf_back.sv @@
// back end: walks the clipped pixel range, writes the frame store, builds results
module crlf_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	input  crlf_pkg::cmd_t                cmd,
	output logic                          cmd_pop,
	input  crlf_pkg::overlay_cfg_t        ovl,
	input  logic                          pop,
	output logic                          empty,
	output logic [crlf_pkg::COLOR_W-1:0]  read_color,
	output logic [crlf_pkg::COUNT_W-1:0]  pixels_written,
	output logic                          rejected
);
	import crlf_pkg::*;

	function automatic logic [ADDR_W-1:0] pix_addr(input logic [COORD_W-1:0] x,
		input logic [COORD_W-1:0] y);
		return ADDR_W'(y) * ADDR_W'(FB_WIDTH) + ADDR_W'(x);
	endfunction

	back_state_t        state_q, state_d;
	logic [COORD_W-1:0] cur_x_q, cur_y_q, x_lo_q, x_hi_q, y_hi_q;
	logic [COLOR_W-1:0] color_q;
	logic               is_top_q;
	logic [COUNT_W-1:0] count_q;
	logic [COLOR_W-1:0] res_color_q;
	logic               res_rej_q;
	logic               out_valid_q;
	logic [COLOR_W-1:0] out_color_q;
	logic [COUNT_W-1:0] out_count_q;
	logic               out_rej_q;

	logic               hidden, last_x, last_y;
	logic               ram_we, ram_re, load_out;
	logic [COLOR_W-1:0] ram_rdata;

	assign hidden = ovl.on && !is_top_q &&
		(cur_x_q >= ovl.left) && (cur_x_q <= ovl.right) &&
		(cur_y_q >= ovl.top) && (cur_y_q <= ovl.bottom);
	assign last_x = (cur_x_q == x_hi_q);
	assign last_y = (cur_y_q == y_hi_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd.kind)
						CK_DRAW: state_d = BK_DRAW;
						CK_READ: state_d = BK_READ;
						default: state_d = BK_DONE;
					endcase
				end
			end
			BK_DRAW: begin
				if (last_x && last_y) begin
					state_d = BK_DONE;
				end
			end
			BK_READ: state_d = BK_DONE;
			BK_DONE: begin
				if (!out_valid_q || pop) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop = (state_q == BK_IDLE) && cmd_valid;
		ram_re = cmd_pop && (cmd.kind == CK_READ);
		ram_we = (state_q == BK_DRAW) && !hidden;
		load_out = (state_q == BK_DONE) && (!out_valid_q || pop);
	end

	crlf_ram #(
		.WIDTH(COLOR_W),
		.DEPTH(FB_DEPTH)
	) u_frame_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(pix_addr(cur_x_q, cur_y_q)),
		.wdata(color_q),
		.re   (ram_re),
		.raddr(pix_addr(cmd.x_lo, cmd.y_lo)),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cur_x_q <= cmd.x_lo;
			cur_y_q <= cmd.y_lo;
			x_lo_q <= cmd.x_lo;
			x_hi_q <= cmd.x_hi;
			y_hi_q <= cmd.y_hi;
			color_q <= cmd.color;
			is_top_q <= cmd.is_top;
			count_q <= '0;
			res_color_q <= '0;
			res_rej_q <= (cmd.kind == CK_REJECT);
		end
		if (state_q == BK_DRAW) begin
			count_q <= count_q + COUNT_W'(ram_we);
			if (last_x) begin
				cur_x_q <= x_lo_q;
				cur_y_q <= cur_y_q + COORD_W'(1);
			end else begin
				cur_x_q <= cur_x_q + COORD_W'(1);
			end
		end
		if (state_q == BK_READ) begin
			res_color_q <= ram_rdata;
		end
		if (load_out) begin
			out_color_q <= res_color_q;
			out_count_q <= count_q;
			out_rej_q <= res_rej_q;
		end
	end

	assign empty = !out_valid_q;
	assign read_color = out_color_q;
	assign pixels_written = out_count_q;
	assign rejected = out_rej_q;

endmodule

@@ sv/clipped_rect_line_fill_engine.sv @@
// top level of the clipped rectangle and line fill engine
// Requests enter through a two-entry queue and are carried out one at a time by a
// pixel sequencer that writes the frame store at one pixel per clock through its
// single write port. A fill or line steps through every pixel of its range after
// clipping to the context and the frame, hidden pixels included, then ends in the
// done state; a pixel read passes through a read state first and a rejected or
// empty request goes straight to the done state. The sequencer then returns to idle
// before it takes the next request, and a request pushed into an idle engine leaves
// the queue in the cycle after it was accepted. Up to two further requests are
// taken while one is drawn, and a finished result waits in an output register while
// the sequencer goes on. The frame store has no reset; the overlay registers should
// be written only while no request is in flight.
module clipped_rect_line_fill_engine (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [crlf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [crlf_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            push,
	output logic                            full,
	input  logic [crlf_pkg::MODE_W-1:0]     mode,
	input  logic [crlf_pkg::COORD_W-1:0]    pos_x,
	input  logic [crlf_pkg::COORD_W-1:0]    pos_y,
	input  logic [crlf_pkg::COORD_W-1:0]    span_x,
	input  logic [crlf_pkg::COORD_W-1:0]    span_y,
	input  logic [crlf_pkg::COLOR_W-1:0]    color,
	input  logic [crlf_pkg::COORD_W-1:0]    ctx_left,
	input  logic [crlf_pkg::COORD_W-1:0]    ctx_top,
	input  logic [crlf_pkg::COORD_W-1:0]    ctx_right,
	input  logic [crlf_pkg::COORD_W-1:0]    ctx_bottom,
	input  logic                            ctx_is_top,
	output logic                            empty,
	input  logic                            pop,
	output logic [crlf_pkg::COLOR_W-1:0]    read_color,
	output logic [crlf_pkg::COUNT_W-1:0]    pixels_written,
	output logic                            rejected
);
	import crlf_pkg::*;

	overlay_cfg_t ovl_q;
	cmd_t         front_cmd, head_cmd;
	logic         head_valid, head_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovl_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OVERLAY_ON: ovl_q.on <= cfg_data[0];
				REG_OV_LEFT: ovl_q.left <= cfg_data[COORD_W-1:0];
				REG_OV_TOP: ovl_q.top <= cfg_data[COORD_W-1:0];
				REG_OV_RIGHT: ovl_q.right <= cfg_data[COORD_W-1:0];
				REG_OV_BOTTOM: ovl_q.bottom <= cfg_data[COORD_W-1:0];
				default: ;
			endcase
		end
	end

	crlf_front u_front (
		.mode      (mode),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.span_x    (span_x),
		.span_y    (span_y),
		.color     (color),
		.ctx_left  (ctx_left),
		.ctx_top   (ctx_top),
		.ctx_right (ctx_right),
		.ctx_bottom(ctx_bottom),
		.ctx_is_top(ctx_is_top),
		.cmd       (front_cmd)
	);

	crlf_cmd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_cmd  (front_cmd),
		.full    (full),
		.rd_en   (head_pop),
		.rd_valid(head_valid),
		.rd_cmd  (head_cmd)
	);

	crlf_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (head_valid),
		.cmd           (head_cmd),
		.cmd_pop       (head_pop),
		.ovl           (ovl_q),
		.pop           (pop),
		.empty         (empty),
		.read_color    (read_color),
		.pixels_written(pixels_written),
		.rejected      (rejected)
	);

endmodule

@@ sv/crlf_checker.sv @@
// port level checks of the fill engine and their binding to the top level
module crlf_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            cfg_we,
	input logic [crlf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [crlf_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic                            push,
	input logic                            full,
	input logic [crlf_pkg::MODE_W-1:0]     mode,
	input logic [crlf_pkg::COORD_W-1:0]    pos_x,
	input logic [crlf_pkg::COORD_W-1:0]    pos_y,
	input logic [crlf_pkg::COORD_W-1:0]    span_x,
	input logic [crlf_pkg::COORD_W-1:0]    span_y,
	input logic [crlf_pkg::COLOR_W-1:0]    color,
	input logic [crlf_pkg::COORD_W-1:0]    ctx_left,
	input logic [crlf_pkg::COORD_W-1:0]    ctx_top,
	input logic [crlf_pkg::COORD_W-1:0]    ctx_right,
	input logic [crlf_pkg::COORD_W-1:0]    ctx_bottom,
	input logic                            ctx_is_top,
	input logic                            empty,
	input logic                            pop,
	input logic [crlf_pkg::COLOR_W-1:0]    read_color,
	input logic [crlf_pkg::COUNT_W-1:0]    pixels_written,
	input logic                            rejected
);

	// a refused request neither draws nor reads
	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && rejected |-> (pixels_written == '0) && (read_color == '0))
		else $error("rejected result carries data");

	// a read never reports stored pixels, a draw never reports a colour
	a_read_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (read_color != '0) |-> (pixels_written == '0) && !rejected)
		else $error("read result mixed with draw result");

	// a waiting result stays put until taken
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(read_color) &&
			$stable(pixels_written) && $stable(rejected))
		else $error("waiting result changed");

endmodule

bind clipped_rect_line_fill_engine crlf_checker u_crlf_checker (.*);

@@ tb/tb_top.sv @@
// self-checking testbench of the clipped rectangle and line fill engine
module tb_top;
	import crlf_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 250000;
	localparam int unsigned PHASES = 6;
	localparam int unsigned ITEMS_PER_PHASE = 308;
	localparam int unsigned LONG_HOLD = 400;
	localparam int unsigned SETTLE_CYCLES = 20;
	localparam int unsigned RECENT_MAX = 256;
	localparam int unsigned CMAX = (1 << COORD_W) - 1;

	typedef struct {
		mode_t mode;
		logic [COORD_W-1:0] px, py, sx, sy;
		logic [COLOR_W-1:0] color;
		logic [COORD_W-1:0] cl, ct, cr, cb;
		logic top;
	} draw_req_t;

	typedef struct {
		logic [COLOR_W-1:0] rd;
		logic [COUNT_W-1:0] cnt;
		logic rej;
	} draw_res_t;

	typedef struct {
		draw_req_t req;
		draw_res_t res;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic push;
	logic full;
	logic [MODE_W-1:0] mode;
	logic [COORD_W-1:0] pos_x, pos_y, span_x, span_y;
	logic [COLOR_W-1:0] color;
	logic [COORD_W-1:0] ctx_left, ctx_top, ctx_right, ctx_bottom;
	logic ctx_is_top;
	logic empty;
	logic pop;
	logic [COLOR_W-1:0] read_color;
	logic [COUNT_W-1:0] pixels_written;
	logic rejected;

	// shadow of the frame store and overlay registers
	logic [COLOR_W-1:0] frame_img [FB_DEPTH];
	bit painted [FB_DEPTH];
	int unsigned recent_addrs [$];
	int unsigned last_addr;
	bit ov_on;
	bit [COORD_W-1:0] ov_l, ov_t, ov_r, ov_b;

	draw_res_t pending_results [$];
	int unsigned mismatches;
	int unsigned n_results;
	int unsigned sent_cnt;
	int unsigned idle_cycles;
	bit [31:0] cyc_cnt;
	bit calm;
	bit hold_request;

	clipped_rect_line_fill_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push),
		.full(full),
		.mode(mode),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.span_x(span_x),
		.span_y(span_y),
		.color(color),
		.ctx_left(ctx_left),
		.ctx_top(ctx_top),
		.ctx_right(ctx_right),
		.ctx_bottom(ctx_bottom),
		.ctx_is_top(ctx_is_top),
		.empty(empty),
		.pop(pop),
		.read_color(read_color),
		.pixels_written(pixels_written),
		.rejected(rejected)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("mismatch: %s", msg);
		mismatches++;
	endtask

	function automatic logic [COORD_W-1:0] rnd10(input int unsigned lo, input int unsigned hi);
		return COORD_W'($urandom_range(hi, lo));
	endfunction

	function automatic bit store_pixel(input int unsigned x, input int unsigned y,
			input logic [COLOR_W-1:0] c, input logic top);
		int unsigned a;
		if (x >= FB_WIDTH || y >= FB_HEIGHT)
			return 1'b0;
		if (ov_on && !top && x >= ov_l && x <= ov_r && y >= ov_t && y <= ov_b)
			return 1'b0;
		a = y * FB_WIDTH + x;
		frame_img[a] = c;
		painted[a] = 1'b1;
		last_addr = a;
		return 1'b1;
	endfunction

	// works out the result of one request and updates the frame shadow
	function automatic draw_res_t paint_request(input draw_req_t r);
		draw_res_t res;
		int unsigned x0, y0, x1, y1, x, y, cnt;
		res.rd = '0;
		res.rej = 1'b0;
		cnt = 0;
		x0 = 32'(r.px) + 32'(r.cl);
		y0 = 32'(r.py) + 32'(r.ct);
		case (r.mode)
			MODE_READ: begin
				if (r.px < FB_WIDTH && r.py < FB_HEIGHT)
					res.rd = frame_img[32'(r.py) * FB_WIDTH + 32'(r.px)];
			end
			MODE_RECT: begin
				if (x0 > r.cr || y0 > r.cb) begin
					res.rej = 1'b1;
				end else if (r.sx != 0 && r.sy != 0) begin
					x1 = x0 + r.sx - 1;
					y1 = y0 + r.sy - 1;
					if (x1 > r.cr) x1 = r.cr;
					if (y1 > r.cb) y1 = r.cb;
					for (y = y0; y <= y1 && y < FB_HEIGHT; y++)
						for (x = x0; x <= x1 && x < FB_WIDTH; x++)
							cnt += store_pixel(x, y, r.color, r.top);
				end
			end
			MODE_HLINE: begin
				if (r.sx < r.px || x0 > r.cr || y0 > r.cb) begin
					res.rej = 1'b1;
				end else begin
					x1 = 32'(r.sx) + 32'(r.cl);
					if (x1 > r.cr) x1 = r.cr;
					for (x = x0; x <= x1 && x < FB_WIDTH; x++)
						cnt += store_pixel(x, y0, r.color, r.top);
				end
			end
			default: begin
				if (r.sy < r.py || x0 > r.cr || y0 > r.cb) begin
					res.rej = 1'b1;
				end else begin
					y1 = 32'(r.sy) + 32'(r.ct);
					if (y1 > r.cb) y1 = r.cb;
					for (y = y0; y <= y1 && y < FB_HEIGHT; y++)
						cnt += store_pixel(x0, y, r.color, r.top);
				end
			end
		endcase
		// remember a few stored pixels so reads can hit written ones
		if (cnt != 0) begin
			recent_addrs.push_back(last_addr);
			if (recent_addrs.size() > RECENT_MAX)
				void'(recent_addrs.pop_front());
		end
		res.cnt = COUNT_W'(cnt);
		return res;
	endfunction

	function automatic stim_row_t mk_row(input mode_t m, input int unsigned px, py, sx, sy, c,
			cl, ct, cr, cb, input bit top, input int unsigned rd, cnt, input bit rej);
		stim_row_t row;
		row.req.mode = m;
		row.req.px = COORD_W'(px);
		row.req.py = COORD_W'(py);
		row.req.sx = COORD_W'(sx);
		row.req.sy = COORD_W'(sy);
		row.req.color = COLOR_W'(c);
		row.req.cl = COORD_W'(cl);
		row.req.ct = COORD_W'(ct);
		row.req.cr = COORD_W'(cr);
		row.req.cb = COORD_W'(cb);
		row.req.top = top;
		row.res.rd = COLOR_W'(rd);
		row.res.cnt = COUNT_W'(cnt);
		row.res.rej = rej;
		return row;
	endfunction

	function automatic draw_req_t make_random_req();
		draw_req_t r;
		int unsigned sel, a, tries;
		sel = $urandom_range(0, 99);
		r.mode = sel < 35 ? MODE_RECT : sel < 55 ? MODE_HLINE : sel < 75 ? MODE_VLINE : MODE_READ;
		r.color = COLOR_W'($urandom());
		r.top = ($urandom_range(0, 3) == 0);
		r.sx = rnd10(0, CMAX);
		r.sy = rnd10(0, CMAX);
		sel = $urandom_range(0, 99);
		if (sel < 65) begin
			r.cl = rnd10(0, FB_WIDTH - 1);
			r.ct = rnd10(0, FB_HEIGHT - 1);
			r.cr = r.cl + rnd10(0, 40);
			r.cb = r.ct + rnd10(0, 40);
		end else if (sel < 85) begin
			r.cl = rnd10(0, CMAX);
			r.ct = rnd10(0, CMAX);
			r.cr = rnd10(0, CMAX);
			r.cb = rnd10(0, CMAX);
		end else begin
			r.cl = '0;
			r.ct = '0;
			r.cr = COORD_W'(FB_WIDTH - 1);
			r.cb = COORD_W'(FB_HEIGHT - 1);
		end
		// mostly start inside the context so requests get past the checks
		r.px = (r.cr >= r.cl && $urandom_range(0, 9) != 0) ? rnd10(0, r.cr - r.cl) : rnd10(0, CMAX);
		r.py = (r.cb >= r.ct && $urandom_range(0, 9) != 0) ? rnd10(0, r.cb - r.ct) : rnd10(0, CMAX);
		sel = $urandom_range(0, 99);
		case (r.mode)
			MODE_RECT: begin
				if (sel < 90) begin
					r.sx = rnd10(0, 12);
					r.sy = rnd10(0, 12);
				end else if (sel < 98) begin
					r.sx = rnd10(0, 80);
					r.sy = rnd10(0, 80);
				end
			end
			MODE_HLINE: begin
				if (sel < 85)
					r.sx = (r.px > CMAX - 40) ? rnd10(r.px, CMAX) : r.px + rnd10(0, 40);
			end
			MODE_VLINE: begin
				if (sel < 85)
					r.sy = (r.py > CMAX - 40) ? rnd10(r.py, CMAX) : r.py + rnd10(0, 40);
			end
			default: begin
				// only pixels already written, or ones outside the frame
				if (sel < 70 && recent_addrs.size() > 0) begin
					a = recent_addrs[$urandom_range(0, recent_addrs.size() - 1)];
					r.px = COORD_W'(a % FB_WIDTH);
					r.py = COORD_W'(a / FB_WIDTH);
				end else if (sel < 85) begin
					tries = 0;
					do begin
						r.px = rnd10(0, FB_WIDTH - 1);
						r.py = rnd10(0, FB_HEIGHT - 1);
						tries++;
					end while (!painted[32'(r.py) * FB_WIDTH + 32'(r.px)] && tries < 16);
					if (!painted[32'(r.py) * FB_WIDTH + 32'(r.px)])
						r.px = rnd10(FB_WIDTH, CMAX);
				end else if ($urandom_range(0, 1) == 0) begin
					r.px = rnd10(FB_WIDTH, CMAX);
					r.py = rnd10(0, CMAX);
				end else begin
					r.px = rnd10(0, CMAX);
					r.py = rnd10(FB_HEIGHT, CMAX);
				end
			end
		endcase
		return r;
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic write_overlay(input bit on, input int unsigned l, t, r, b);
		ov_on = on;
		ov_l = COORD_W'(l);
		ov_t = COORD_W'(t);
		ov_r = COORD_W'(r);
		ov_b = COORD_W'(b);
		cfg_we <= 1'b1;
		cfg_index <= REG_OVERLAY_ON;
		cfg_data <= CFG_DATA_W'(on);
		@(negedge clk);
		cfg_index <= REG_OV_LEFT;
		cfg_data <= CFG_DATA_W'(l);
		@(negedge clk);
		cfg_index <= REG_OV_TOP;
		cfg_data <= CFG_DATA_W'(t);
		@(negedge clk);
		cfg_index <= REG_OV_RIGHT;
		cfg_data <= CFG_DATA_W'(r);
		@(negedge clk);
		cfg_index <= REG_OV_BOTTOM;
		cfg_data <= CFG_DATA_W'(b);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic issue_request(input draw_req_t r, input bit known, input draw_res_t want);
		draw_res_t predicted;
		if (!calm && !sent_cnt[5] && $urandom_range(0, 3) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		push <= 1'b1;
		mode <= r.mode;
		pos_x <= r.px;
		pos_y <= r.py;
		span_x <= r.sx;
		span_y <= r.sy;
		color <= r.color;
		ctx_left <= r.cl;
		ctx_top <= r.ct;
		ctx_right <= r.cr;
		ctx_bottom <= r.cb;
		ctx_is_top <= r.top;
		do @(posedge clk); while (full);
		predicted = paint_request(r);
		pending_results.push_back(known ? want : predicted);
		sent_cnt++;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		push <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	initial begin : stimulus
		stim_row_t rows [$];
		draw_res_t no_res;
		int unsigned l, t;
		no_res = '{rd: '0, cnt: '0, rej: 1'b0};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		push = 1'b0;
		mode = '0;
		pos_x = '0;
		pos_y = '0;
		span_x = '0;
		span_y = '0;
		color = '0;
		ctx_left = '0;
		ctx_top = '0;
		ctx_right = '0;
		ctx_bottom = '0;
		ctx_is_top = 1'b0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// overlay over columns and rows 10..19
		write_overlay(1'b1, 10, 10, 19, 19);
		rows.push_back(mk_row(MODE_RECT, 0, 0, 20, 20, 'hFFFFFF, 0, 0, 319, 239, 0, 0, 300, 0));
		rows.push_back(mk_row(MODE_RECT, 0, 0, 20, 20, 'h000001, 0, 0, 319, 239, 1, 0, 400, 0));
		rows.push_back(mk_row(MODE_READ, 15, 15, 0, 0, 0, 0, 0, 0, 0, 0, 'h000001, 0, 0));
		rows.push_back(mk_row(MODE_READ, 5, 5, 0, 0, 0, 0, 0, 0, 0, 0, 'h000001, 0, 0));
		// start past the right edge, then past the bottom edge
		rows.push_back(mk_row(MODE_RECT, 10, 0, 1, 1, 'h111111, 310, 0, 319, 239, 0, 0, 0, 1));
		rows.push_back(mk_row(MODE_RECT, 0, 10, 1, 1, 'h222222, 0, 230, 319, 239, 0, 0, 0, 1));
		rows.push_back(mk_row(MODE_RECT, 30, 30, 0, 5, 'h333333, 0, 0, 319, 239, 0, 0, 0, 0));
		rows.push_back(mk_row(MODE_RECT, 30, 30, 5, 0, 'h444444, 0, 0, 319, 239, 0, 0, 0, 0));
		// lines running backwards
		rows.push_back(mk_row(MODE_HLINE, 5, 5, 4, 0, 'h555555, 0, 0, 319, 239, 0, 0, 0, 1));
		rows.push_back(mk_row(MODE_VLINE, 5, 5, 0, 4, 'h666666, 0, 0, 319, 239, 0, 0, 0, 1));
		// line ends clamped to the context
		rows.push_back(mk_row(MODE_HLINE, 2, 3, 1023, 0, 'h123456, 100, 50, 109, 59, 0, 0, 8, 0));
		rows.push_back(mk_row(MODE_VLINE, 0, 0, 0, 1023, 'h654321, 200, 100, 209, 119, 0, 0, 20,
			0));
		// clipped by the frame edge
		rows.push_back(mk_row(MODE_RECT, 0, 0, 1023, 1023, 'hC0FFEE, 300, 220, 1023, 1023, 0, 0,
			400, 0));
		rows.push_back(mk_row(MODE_HLINE, 0, 5, 1023, 0, 'h777777, 310, 0, 1023, 1023, 0, 0, 10,
			0));
		rows.push_back(mk_row(MODE_READ, 320, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		rows.push_back(mk_row(MODE_READ, 1023, 1023, 1023, 1023, 'hFFFFFF, 1023, 1023, 1023, 1023,
			1, 0, 0, 0));
		rows.push_back(mk_row(MODE_RECT, 0, 0, 1, 1, 'h888888, 1023, 1023, 1023, 1023, 0, 0, 0,
			0));
		rows.push_back(mk_row(MODE_RECT, 1023, 1023, 1, 1, 'h999999, 1023, 1023, 1023, 1023, 0, 0,
			0, 1));
		// vertical line through the overlay, hidden part skipped
		rows.push_back(mk_row(MODE_VLINE, 12, 0, 0, 30, 'hABCDEF, 0, 0, 319, 239, 0, 0, 21, 0));
		rows.push_back(mk_row(MODE_READ, 12, 25, 0, 0, 0, 0, 0, 0, 0, 0, 'hABCDEF, 0, 0));
		rows.push_back(mk_row(MODE_HLINE, 0, 15, 319, 0, 'h5A5A5A, 0, 0, 319, 239, 1, 0, 320, 0));
		rows.push_back(mk_row(MODE_READ, 319, 15, 0, 0, 0, 0, 0, 0, 0, 0, 'h5A5A5A, 0, 0));
		rows.push_back(mk_row(MODE_READ, 319, 239, 0, 0, 0, 0, 0, 0, 0, 0, 'hC0FFEE, 0, 0));
		rows.push_back(mk_row(MODE_VLINE, 319, 0, 0, 239, 'h000000, 0, 0, 319, 239, 0, 0, 240, 0));
		rows.push_back(mk_row(MODE_READ, 319, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		foreach (rows[i])
			issue_request(rows[i].req, 1'b1, rows[i].res);
		wait_idle();

		for (int ph = 0; ph < PHASES; ph++) begin
			l = $urandom_range(0, FB_WIDTH - 20);
			t = $urandom_range(0, FB_HEIGHT - 20);
			case (ph)
				0: write_overlay(1'b1, 0, 0, CMAX, CMAX);
				1: write_overlay(1'b0, rnd10(0, CMAX), rnd10(0, CMAX), rnd10(0, CMAX),
					rnd10(0, CMAX));
				2: write_overlay(1'b1, CMAX, CMAX, 0, 0);
				4: write_overlay(1'b1, rnd10(0, CMAX), rnd10(0, CMAX), rnd10(0, CMAX),
					rnd10(0, CMAX));
				default: write_overlay(1'b1, l, t, l + $urandom_range(0, 60),
					t + $urandom_range(0, 60));
			endcase
			calm = (ph == PHASES - 1);
			if (ph == 3)
				hold_request = 1'b1;
			for (int i = 0; i < ITEMS_PER_PHASE; i++)
				issue_request(make_random_req(), 1'b0, no_res);
			wait_idle();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// result side: random stalls and one long hold-off
	initial begin : result_sink
		int unsigned stall;
		stall = 0;
		pop = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				stall = LONG_HOLD;
			end
			if (stall > 0) begin
				pop <= 1'b0;
				stall--;
			end else if (!calm && !cyc_cnt[8] && $urandom_range(0, 3) == 0) begin
				pop <= 1'b0;
				stall = $urandom_range(0, 2);
			end else begin
				pop <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		draw_res_t want;
		if (arst_n && pop && !empty) begin
			n_results++;
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with no request pending", n_results));
			end else begin
				want = pending_results.pop_front();
				if (read_color !== want.rd)
					report_mismatch($sformatf("result %0d read_color 0x%0h expected 0x%0h",
						n_results, read_color, want.rd));
				if (pixels_written !== want.cnt)
					report_mismatch($sformatf("result %0d pixels_written %0d expected %0d",
						n_results, pixels_written, want.cnt));
				if (rejected !== want.rej)
					report_mismatch($sformatf("result %0d rejected %0b expected %0b",
						n_results, rejected, want.rej));
			end
		end
	end

	// watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		cyc_cnt <= cyc_cnt + 1;
		if (!arst_n || (push && !full) || (pop && !empty))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

endmodule

@@ sim.f @@
sv/crlf_pkg.sv
sv/crlf_ram.sv
sv/crlf_front.sv
sv/crlf_cmd_queue.sv
sv/crlf_back.sv
sv/clipped_rect_line_fill_engine.sv
sv/crlf_checker.sv
tb/tb_top.sv
